>>> design/assert_macros.svh
// Assertion helpers for the design files, included by the normalize unit.
// Both macros sample on the rising edge of clk and are off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> design/smcn_pkg.sv
package smcn_pkg;

    localparam int SAMPLE_W       = 12;
    localparam int CH_W           = 2;
    localparam int NORM_W         = 10;
    localparam int CHANNELS_DEF   = 4;
    localparam int FULL_SCALE_DEF = 1000;

    localparam logic [SAMPLE_W-1:0] MAX_RESET = '0;
    localparam logic [SAMPLE_W-1:0] MIN_RESET = '1;

    localparam logic OP_CALIBRATE = 1'b0;
    localparam logic OP_NORMALIZE = 1'b1;

    // Command to the range store for the current request.
    typedef struct packed {
        logic cal;
        logic hit;
    } store_cmd_t;

    // Status of the shared divider.
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

>>> design/sensor_minmax_calibrate_normalize_unit.sv
// Channel   Ports                                     Direction
// input     in_valid, in_ready, operation,            in  (in_ready out)
//           channel, sample
// output    out_valid, out_ready, normalized,         out (out_ready in)
//           stored_max, stored_min, span_fault
//
// A request passes through LOOK, EVAL and DONE when no division is needed
// (calibrate, span fault, or sample at least a full span away from the
// minimum) and also through MUL and DIV otherwise. The restoring divider
// retires one of the FS_W = clog2(FULL_SCALE + 1) quotient bits per cycle.
// Reset sets every channel maximum to 0 and minimum to 4095.
// A new request is taken while a result still waits on out_ready; the next
// result then holds until the output register is free.
`include "assert_macros.svh"

module sensor_minmax_calibrate_normalize_unit #(
    parameter int CHANNELS   = smcn_pkg::CHANNELS_DEF,
    parameter int FULL_SCALE = smcn_pkg::FULL_SCALE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          operation,
    input  logic [smcn_pkg::CH_W-1:0]     channel,
    input  logic [smcn_pkg::SAMPLE_W-1:0] sample,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [smcn_pkg::NORM_W-1:0]   normalized,
    output logic [smcn_pkg::SAMPLE_W-1:0] stored_max,
    output logic [smcn_pkg::SAMPLE_W-1:0] stored_min,
    output logic                          span_fault
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int FS_W  = $clog2(FULL_SCALE + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOOK = 3'd1;
    localparam logic [2:0] S_EVAL = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]                    state_reg;
    logic [2:0]                    state_next;
    logic                          op_reg;
    logic [smcn_pkg::CH_W-1:0]     ch_reg;
    logic [smcn_pkg::SAMPLE_W-1:0] sample_reg;
    logic [smcn_pkg::SAMPLE_W-1:0] hi_reg;
    logic [smcn_pkg::SAMPLE_W-1:0] lo_reg;
    logic                          fault_reg;
    logic                          neg_reg;
    logic [smcn_pkg::SAMPLE_W-1:0] mag_reg;
    logic [smcn_pkg::SAMPLE_W-1:0] span_reg;
    logic [FS_W-1:0]               norm_reg;

    logic                          out_valid_reg;
    logic [smcn_pkg::NORM_W-1:0]   normalized_reg;
    logic [smcn_pkg::SAMPLE_W-1:0] stored_max_reg;
    logic [smcn_pkg::SAMPLE_W-1:0] stored_min_reg;
    logic                          span_fault_reg;

    smcn_pkg::store_cmd_t          store_cmd;
    logic [IDX_W-1:0]              ch_idx;
    logic [smcn_pkg::SAMPLE_W-1:0] rd_max;
    logic [smcn_pkg::SAMPLE_W-1:0] rd_min;
    smcn_pkg::div_stat_t           div_stat;
    logic [FS_W-1:0]               quot;

    logic                          accept;
    logic                          out_free;
    logic                          fault_c;
    logic                          neg_c;
    logic [smcn_pkg::SAMPLE_W-1:0] mag_c;
    logic [smcn_pkg::SAMPLE_W-1:0] span_c;
    logic                          big_c;
    logic [31:0]                   norm_wide;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    assign ch_idx        = IDX_W'(ch_reg);
    assign store_cmd.hit = (32'(ch_reg) < CHANNELS);
    assign store_cmd.cal = (state_reg == S_LOOK) && (op_reg == smcn_pkg::OP_CALIBRATE);

    smcn_store #(
        .CHANNELS (CHANNELS),
        .IDX_W    (IDX_W)
    ) u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (store_cmd),
        .idx    (ch_idx),
        .sample (sample_reg),
        .rd_max (rd_max),
        .rd_min (rd_min)
    );

    smcn_divider #(
        .FULL_SCALE (FULL_SCALE),
        .FS_W       (FS_W)
    ) u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_MUL),
        .mag   (mag_reg),
        .span  (span_reg),
        .stat  (div_stat),
        .quot  (quot)
    );

    // Range checks on the range read back after a calibrate update.
    assign fault_c = (op_reg == smcn_pkg::OP_NORMALIZE) && (rd_max <= rd_min);
    assign neg_c   = sample_reg < rd_min;
    assign mag_c   = neg_c ? (rd_min - sample_reg) : (sample_reg - rd_min);
    assign span_c  = rd_max - rd_min;
    // At least one full span away means the quotient reaches full scale.
    assign big_c   = mag_c >= span_c;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if ((op_reg == smcn_pkg::OP_NORMALIZE) && !fault_c && !big_c)
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_MUL:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= operation;
            ch_reg     <= channel;
            sample_reg <= sample;
        end
        if (state_reg == S_EVAL)
        begin
            hi_reg    <= rd_max;
            lo_reg    <= rd_min;
            fault_reg <= fault_c;
            neg_reg   <= neg_c;
            mag_reg   <= mag_c;
            span_reg  <= span_c;
            if ((op_reg == smcn_pkg::OP_CALIBRATE) || fault_c)
            begin
                norm_reg <= '0;
            end
            else if (neg_c)
            begin
                norm_reg <= FS_W'(1);
            end
            else
            begin
                norm_reg <= FS_W'(FULL_SCALE);
            end
        end
        else if ((state_reg == S_DIV) && div_stat.done)
        begin
            // Below the minimum only a nonzero truncated quotient reports 1.
            norm_reg <= neg_reg ? FS_W'(quot != '0) : quot;
        end
    end

    assign norm_wide = 32'(norm_reg);

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_DONE) && out_free)
        begin
            normalized_reg <= norm_wide[smcn_pkg::NORM_W-1:0];
            stored_max_reg <= hi_reg;
            stored_min_reg <= lo_reg;
            span_fault_reg <= fault_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == S_DONE) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign normalized = normalized_reg;
    assign stored_max = stored_max_reg;
    assign stored_min = stored_min_reg;
    assign span_fault = span_fault_reg;

    `ASSERT_SAME(a_fault_zero, out_valid && span_fault, normalized == '0)
    `ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    `ASSERT_SAME(a_div_in_div_state, div_stat.busy, state_reg == S_DIV)
    `ASSERT_SAME(a_no_result_overwrite, (state_reg == S_DONE) && out_valid && !out_ready, state_next == S_DONE)

endmodule

>>> design/smcn_store.sv
module smcn_store #(
    parameter int CHANNELS = smcn_pkg::CHANNELS_DEF,
    parameter int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  smcn_pkg::store_cmd_t          cmd,
    input  logic [IDX_W-1:0]              idx,
    input  logic [smcn_pkg::SAMPLE_W-1:0] sample,
    output logic [smcn_pkg::SAMPLE_W-1:0] rd_max,
    output logic [smcn_pkg::SAMPLE_W-1:0] rd_min
);

    logic [smcn_pkg::SAMPLE_W-1:0] max_reg [CHANNELS];
    logic [smcn_pkg::SAMPLE_W-1:0] min_reg [CHANNELS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                max_reg[i] <= smcn_pkg::MAX_RESET;
                min_reg[i] <= smcn_pkg::MIN_RESET;
            end
        end
        else if (cmd.cal && cmd.hit)
        begin
            if (sample > max_reg[idx])
            begin
                max_reg[idx] <= sample;
            end
            if (sample < min_reg[idx])
            begin
                min_reg[idx] <= sample;
            end
        end
    end

    // A channel outside the store reads as an untouched channel.
    assign rd_max = cmd.hit ? max_reg[idx] : smcn_pkg::MAX_RESET;
    assign rd_min = cmd.hit ? min_reg[idx] : smcn_pkg::MIN_RESET;

endmodule

>>> design/smcn_divider.sv
module smcn_divider #(
    parameter int FULL_SCALE = smcn_pkg::FULL_SCALE_DEF,
    parameter int FS_W       = $clog2(FULL_SCALE + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [smcn_pkg::SAMPLE_W-1:0] mag,
    input  logic [smcn_pkg::SAMPLE_W-1:0] span,
    output smcn_pkg::div_stat_t           stat,
    output logic [FS_W-1:0]               quot
);

    localparam int PROD_W = smcn_pkg::SAMPLE_W + FS_W;
    localparam int CNT_W  = $clog2(FS_W + 1);

    logic [PROD_W-1:0]               prod;
    logic [smcn_pkg::SAMPLE_W-1:0]   rem_reg;
    logic [FS_W-1:0]                 quo_reg;
    logic [CNT_W-1:0]                cnt_reg;
    logic                            done_reg;
    logic [smcn_pkg::SAMPLE_W:0]     trial;
    logic [smcn_pkg::SAMPLE_W:0]     diff;
    logic                            ge;

    assign prod  = PROD_W'(mag) * PROD_W'(FULL_SCALE);
    assign trial = {rem_reg, quo_reg[FS_W-1]};
    assign ge    = trial >= {1'b0, span};
    assign diff  = trial - {1'b0, span};

    // The caller only starts a division when mag is below span, so the quotient
    // fits in FS_W bits and the upper product bits are already below span.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= prod[PROD_W-1:FS_W];
            quo_reg <= prod[FS_W-1:0];
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= ge ? diff[smcn_pkg::SAMPLE_W-1:0] : trial[smcn_pkg::SAMPLE_W-1:0];
            quo_reg <= FS_W'({quo_reg, ge});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CNT_W'(1));
            if (start)
            begin
                cnt_reg <= CNT_W'(FS_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;
    assign quot      = quo_reg;

endmodule
